/* design/max_tracking_queue_top_macros.svh */
// Assertion macros shared by the verification files of the max tracking queue.
// No dependencies; included by the checker module.
`ifndef MAX_TRACKING_QUEUE_TOP_MACROS_SVH
`define MAX_TRACKING_QUEUE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MTQ_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max tracking queue: implication check failed");

// Signal holds its value in the cycle after the condition.
`define MTQ_ASSERT_HOLD(label, clk, rst, cond, sig) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error("max tracking queue: stalled response changed");

`endif

/* design/mtq_pkg.sv */
// Shared types, codes and helpers of the max tracking queue.
// No dependencies; used by every other file of the block but the macros header.
`timescale 1ns / 1ps

package mtq_pkg;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_DEQ_EMPTY = 2'd1;
   localparam status_type STATUS_ENQ_FULL  = 2'd2;

   // One stored entry: value and the maximum of the stack up to and including it.
   typedef struct packed {
      logic signed [31:0] run_max;
      logic signed [31:0] value;
   } entry_type;

   function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* design/mtq_if.sv */
// Valid/ready channel interfaces for the request and response items.
// Depends on mtq_pkg for the status type.
`timescale 1ns / 1ps

interface mtq_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [31:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mtq_rsp_if;
   logic                   valid;
   logic                   ready;
   logic signed [31:0]     dequeued;
   logic                   is_empty;
   logic signed [31:0]     current_max;
   mtq_pkg::status_type    status;

   modport source (output valid, output dequeued, output is_empty, output current_max,
                   output status, input ready);
   modport sink   (input valid, input dequeued, input is_empty, input current_max,
                   input status, output ready);
endinterface

/* design/max_tracking_queue_top.sv */
// Max tracking queue: a FIFO of signed 32-bit values reporting its maximum.
//
// Channels: req_chan (sink) takes one item per operation: req_type 0 enqueues
// value, req_type 1 dequeues the oldest value. rsp_chan (source) returns one
// item per request: dequeued value, is_empty, current_max (0 when empty) and
// status (ok, dequeue from empty ignored, enqueue into full dropped).
// Both handshake on valid and ready at a rising clock edge.
// Steps from accept to response: an enqueue, dropped or not, and a dequeue
// from empty go straight to ST_DONE, which loads the response register. A
// dequeue goes to ST_POP, then to ST_POP_LD when an entry lies beneath to
// refill the cached back top, then to ST_DONE; if the back stack is empty it
// first moves every front entry, newest first, through ST_XFER_RD and
// ST_XFER_WR. Each entry moves at most once, and each move reads and then
// writes the single entry store.
// One request is in work at a time; the next is taken once the result sits
// in the response register, even while the receiver stalls it. A stalled
// response holds and the following result waits in the sequencer.
// Reset (synchronous) empties both stacks at once; the store needs no clearing.
// Depends on mtq_pkg, mtq_if, mtq_store and mtq_ctrl.
`timescale 1ns / 1ps

module max_tracking_queue_top #(
   parameter int DEPTH = 1024
) (
   input logic          clock,
   input logic          reset,
   mtq_req_if.sink      req_chan,
   mtq_rsp_if.source    rsp_chan
);

   localparam int AW = $clog2(DEPTH);

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   mtq_pkg::entry_type   wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   mtq_pkg::entry_type   rd_data;

   mtq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_op          (req_chan.req_type),
      .req_value       (req_chan.value),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_dequeued    (rsp_chan.dequeued),
      .rsp_is_empty    (rsp_chan.is_empty),
      .rsp_current_max (rsp_chan.current_max),
      .rsp_status      (rsp_chan.status),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   mtq_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

/* design/mtq_store.sv */
// Entry store of the max tracking queue: one write port, one registered read port.
// Depends on mtq_pkg for the entry layout.
`timescale 1ns / 1ps

module mtq_store #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  mtq_pkg::entry_type         wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output mtq_pkg::entry_type         rd_data
);

   mtq_pkg::entry_type mem [DEPTH];
   mtq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mtq_ctrl.sv */
// Sequencer of the max tracking queue: stack pointers, cached stack tops,
// front-to-back transfer and the response register. Depends on mtq_pkg.
`timescale 1ns / 1ps

module mtq_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [31:0]         rsp_dequeued,
   output logic                       rsp_is_empty,
   output logic signed [31:0]         rsp_current_max,
   output mtq_pkg::status_type        rsp_status,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output mtq_pkg::entry_type         wr_data,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   input  mtq_pkg::entry_type         rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_XFER_RD = 3'd1;
   localparam logic [2:0] ST_XFER_WR = 3'd2;
   localparam logic [2:0] ST_POP     = 3'd3;
   localparam logic [2:0] ST_POP_LD  = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        front_cnt_ff, front_cnt_in;
   logic [CW-1:0]        back_cnt_ff, back_cnt_in;
   logic signed [31:0]   front_max_ff, front_max_in;
   logic signed [31:0]   back_val_ff, back_val_in;
   logic signed [31:0]   back_max_ff, back_max_in;
   logic signed [31:0]   deq_ff, deq_in;
   mtq_pkg::status_type  status_ff, status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_deq_ff, rsp_deq_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic signed [31:0]   rsp_max_ff, rsp_max_in;
   mtq_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic                 front_empty;
   logic                 back_empty;
   logic                 full;
   logic [CW-1:0]        front_dec;
   logic [CW-1:0]        back_dec;
   logic [CW-1:0]        back_free;
   logic [CW-1:0]        back_next_top;
   logic signed [31:0]   push_max;
   logic signed [31:0]   move_max;
   logic signed [31:0]   cur_max;

   assign front_empty   = (front_cnt_ff == '0);
   assign back_empty    = (back_cnt_ff == '0);
   assign full          = ({1'b0, front_cnt_ff} + {1'b0, back_cnt_ff}) == {1'b0, DEPTH_C};
   assign front_dec     = front_cnt_ff - ONE_C;
   assign back_dec      = back_cnt_ff - ONE_C;
   assign back_free     = DEPTH_C - ONE_C - back_cnt_ff;
   assign back_next_top = DEPTH_C - back_dec;
   assign push_max      = front_empty ? req_value : mtq_pkg::smax(front_max_ff, req_value);
   assign move_max      = back_empty ? rd_data.value
                                     : mtq_pkg::smax(back_max_ff, rd_data.value);

   always_comb begin
      priority if (front_empty && back_empty) begin
         cur_max = '0;
      end else if (front_empty) begin
         cur_max = back_max_ff;
      end else if (back_empty) begin
         cur_max = front_max_ff;
      end else begin
         cur_max = mtq_pkg::smax(front_max_ff, back_max_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      front_cnt_in  = front_cnt_ff;
      back_cnt_in   = back_cnt_ff;
      front_max_in  = front_max_ff;
      back_val_in   = back_val_ff;
      back_max_in   = back_max_ff;
      deq_in        = deq_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_deq_in    = rsp_deq_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               deq_in   = '0;
               state_in = ST_DONE;
               if (req_op == mtq_pkg::OP_ENQ) begin
                  if (full) begin
                     status_in = mtq_pkg::STATUS_ENQ_FULL;
                  end else begin
                     status_in     = mtq_pkg::STATUS_OK;
                     wr_en         = 1'b1;
                     wr_addr       = front_cnt_ff[AW-1:0];
                     wr_data.value = req_value;
                     wr_data.run_max = push_max;
                     front_max_in  = push_max;
                     front_cnt_in  = front_cnt_ff + ONE_C;
                  end
               end else begin
                  if (front_empty && back_empty) begin
                     status_in = mtq_pkg::STATUS_DEQ_EMPTY;
                  end else begin
                     status_in = mtq_pkg::STATUS_OK;
                     state_in  = back_empty ? ST_XFER_RD : ST_POP;
                  end
               end
            end
         end
         ST_XFER_RD: begin
            // take the newest front entry
            rd_en        = 1'b1;
            rd_addr      = front_dec[AW-1:0];
            front_cnt_in = front_dec;
            state_in     = ST_XFER_WR;
         end
         ST_XFER_WR: begin
            wr_en           = 1'b1;
            wr_addr         = back_free[AW-1:0];
            wr_data.value   = rd_data.value;
            wr_data.run_max = move_max;
            back_val_in     = rd_data.value;
            back_max_in     = move_max;
            back_cnt_in     = back_cnt_ff + ONE_C;
            state_in        = front_empty ? ST_POP : ST_XFER_RD;
         end
         ST_POP: begin
            deq_in      = back_val_ff;
            back_cnt_in = back_dec;
            if (back_dec != '0) begin
               // refill the cached back top from the entry beneath
               rd_en    = 1'b1;
               rd_addr  = back_next_top[AW-1:0];
               state_in = ST_POP_LD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP_LD: begin
            back_val_in = rd_data.value;
            back_max_in = rd_data.run_max;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_deq_in    = deq_ff;
               rsp_empty_in  = front_empty && back_empty;
               rsp_max_in    = cur_max;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_max_ff  <= front_max_in;
      back_val_ff   <= back_val_in;
      back_max_ff   <= back_max_in;
      deq_ff        <= deq_in;
      status_ff     <= status_in;
      rsp_deq_ff    <= rsp_deq_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dequeued    = rsp_deq_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_current_max = rsp_max_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

/* design/mtq_checker.sv */
// Port-level checks of the max tracking queue response channel, bound to the top.
// Depends on mtq_pkg and max_tracking_queue_top_macros.svh.
`timescale 1ns / 1ps
`include "max_tracking_queue_top_macros.svh"

module mtq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic signed [31:0]    rsp_dequeued,
   input logic                  rsp_is_empty,
   input logic signed [31:0]    rsp_current_max,
   input mtq_pkg::status_type   rsp_status
);

   logic rsp_stall;
   logic shown_empty;
   logic deq_err;
   logic any_err;
   logic full_err;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign shown_empty = rsp_valid && rsp_is_empty;
   assign deq_err     = rsp_valid && (rsp_status == mtq_pkg::STATUS_DEQ_EMPTY);
   assign any_err     = rsp_valid && (rsp_status != mtq_pkg::STATUS_OK);
   assign full_err    = rsp_valid && (rsp_status == mtq_pkg::STATUS_ENQ_FULL);

   `MTQ_ASSERT_HOLD(a_stall_max_hold, clock, reset, rsp_stall, rsp_current_max)
   `MTQ_ASSERT_IMPLIES(a_empty_max_zero, clock, reset, shown_empty, rsp_current_max == 32'sd0)
   `MTQ_ASSERT_IMPLIES(a_deq_empty_is_empty, clock, reset, deq_err, rsp_is_empty)
   `MTQ_ASSERT_IMPLIES(a_error_no_value, clock, reset, any_err, rsp_dequeued == 32'sd0)
   `MTQ_ASSERT_IMPLIES(a_full_not_empty, clock, reset, full_err, !rsp_is_empty)

endmodule

bind max_tracking_queue_top mtq_checker u_mtq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_dequeued    (rsp_chan.dequeued),
   .rsp_is_empty    (rsp_chan.is_empty),
   .rsp_current_max (rsp_chan.current_max),
   .rsp_status      (rsp_chan.status)
);

/* tb/sv/tb_max_tracking_queue_top.sv */
// Self-checking testbench for max_tracking_queue_top: a two-stack model of the
// queue predicts every response item and a scoreboard class compares them in order.
// Depends on mtq_pkg, mtq_if and the RTL of max_tracking_queue_top.
`timescale 1ns / 1ps

module tb_max_tracking_queue_top;

   localparam int QUEUE_DEPTH  = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TICKS = 20;

   typedef struct {
      logic signed [31:0]  dequeued;
      logic                is_empty;
      logic signed [31:0]  current_max;
      mtq_pkg::status_type status;
   } queue_result_type;

   // Two stacks in one slot array: the inbox grows up from slot 0 and takes
   // enqueues, the outbox grows down from the last slot and serves dequeues.
   class running_max_checker_type;
      mtq_pkg::entry_type slots [QUEUE_DEPTH];
      int                 inbox_top;
      int                 outbox_top;
      queue_result_type   awaited_results [$];
      int                 error_count;

      function new();
         inbox_top   = 0;
         outbox_top  = QUEUE_DEPTH - 1;
         error_count = 0;
      endfunction

      function logic signed [31:0] larger(logic signed [31:0] a, logic signed [31:0] b);
         return (a > b) ? a : b;
      endfunction

      function bit inbox_empty();
         return inbox_top == 0;
      endfunction

      function bit outbox_empty();
         return outbox_top == QUEUE_DEPTH - 1;
      endfunction

      function void push_inbox(logic signed [31:0] v);
         mtq_pkg::entry_type e;
         e.value = v;
         if (inbox_empty())
            e.run_max = v;
         else
            e.run_max = larger(slots[inbox_top - 1].run_max, v);
         slots[inbox_top] = e;
         inbox_top++;
      endfunction

      function void push_outbox(logic signed [31:0] v);
         mtq_pkg::entry_type e;
         e.value = v;
         if (outbox_empty())
            e.run_max = v;
         else
            e.run_max = larger(slots[outbox_top + 1].run_max, v);
         slots[outbox_top] = e;
         outbox_top--;
      endfunction

      function logic signed [31:0] held_max();
         if (inbox_empty() && outbox_empty())
            return 32'sd0;
         if (inbox_empty())
            return slots[outbox_top + 1].run_max;
         if (outbox_empty())
            return slots[inbox_top - 1].run_max;
         return larger(slots[inbox_top - 1].run_max, slots[outbox_top + 1].run_max);
      endfunction

      function void note_request(logic op, logic signed [31:0] v);
         queue_result_type r;
         r.dequeued = 32'sd0;
         r.status   = mtq_pkg::STATUS_OK;
         if (op == mtq_pkg::OP_ENQ) begin
            if (inbox_top > outbox_top)
               r.status = mtq_pkg::STATUS_ENQ_FULL;
            else
               push_inbox(v);
         end else begin
            if (inbox_empty() && outbox_empty()) begin
               r.status = mtq_pkg::STATUS_DEQ_EMPTY;
            end else begin
               // refill the outbox newest first so the oldest item ends on top
               if (outbox_empty()) begin
                  while (!inbox_empty()) begin
                     inbox_top--;
                     push_outbox(slots[inbox_top].value);
                  end
               end
               outbox_top++;
               r.dequeued = slots[outbox_top].value;
            end
         end
         r.is_empty    = inbox_empty() && outbox_empty();
         r.current_max = held_max();
         awaited_results.push_back(r);
      endfunction

      function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            error_count++;
         end
      endfunction

      function void check_response(logic signed [31:0] dequeued, logic is_empty,
                                   logic signed [31:0] current_max,
                                   mtq_pkg::status_type status);
         queue_result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: response item with none outstanding, dequeued %0d max %0d status %0d",
                     $time, dequeued, current_max, status);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         compare("dequeued", want.dequeued, dequeued);
         compare("is_empty", 32'(want.is_empty), 32'(is_empty));
         compare("current_max", want.current_max, current_max);
         compare("status", 32'(want.status), 32'(status));
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mtq_req_if req_chan ();
   mtq_rsp_if rsp_chan ();

   max_tracking_queue_top #(.DEPTH(QUEUE_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   running_max_checker_type checker_q = new();

   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_request    = 1'b0;
   int level           = 0;   // occupancy as the sender sees it
   int served          = 0;   // items that the queue acted on
   int cycle_count     = 0;

   // Check before noting so a stray response never meets a fresh expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            checker_q.check_response(rsp_chan.dequeued, rsp_chan.is_empty,
                                     rsp_chan.current_max, rsp_chan.status);
         if (req_chan.valid && req_chan.ready)
            checker_q.note_request(req_chan.req_type, req_chan.value);
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(0, 20)) - 32'sd10;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_op(logic op, logic signed [31:0] v);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.value    <= v;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (op == mtq_pkg::OP_ENQ) begin
         if (level < QUEUE_DEPTH) begin
            level++;
            served++;
         end
      end else if (level > 0) begin
         level--;
         served++;
      end
   endtask

   // Run until count items were acted on; drops and empty dequeues do not count.
   task automatic random_ops(int count, int enq_pct);
      int goal;
      goal = served + count;
      while (served < goal)
         send_op(($urandom_range(0, 99) < enq_pct) ? mtq_pkg::OP_ENQ : mtq_pkg::OP_DEQ,
                 pick_value());
   endtask

   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= mtq_pkg::OP_ENQ;
      req_chan.value    <= 32'sd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      send_op(mtq_pkg::OP_DEQ, 32'sd0);
      send_op(mtq_pkg::OP_ENQ, 32'sh7FFFFFFF);
      send_op(mtq_pkg::OP_ENQ, 32'sh80000000);
      send_op(mtq_pkg::OP_ENQ, -32'sd1);
      send_op(mtq_pkg::OP_ENQ, 32'sd0);
      send_op(mtq_pkg::OP_DEQ, 32'sh12345678);
      send_op(mtq_pkg::OP_ENQ, 32'sh55555555);
      send_op(mtq_pkg::OP_ENQ, 32'shAAAAAAAA);
      repeat (6) send_op(mtq_pkg::OP_DEQ, -32'sd1);
      send_op(mtq_pkg::OP_ENQ, 32'sh80000000);
      send_op(mtq_pkg::OP_DEQ, 32'sd0);
      send_op(mtq_pkg::OP_DEQ, 32'sd0);
      send_op(mtq_pkg::OP_ENQ, 32'sd1);
      send_op(mtq_pkg::OP_ENQ, -32'sd7);
      send_op(mtq_pkg::OP_DEQ, 32'sd0);

      // long receiver hold while the sender keeps offering
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      random_ops(80, 70);

      sender_gaps = 1'b1;
      random_ops(200, 50);

      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      random_ops(60, 50);

      // fill to capacity, then push a few that must be dropped
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      while (level < QUEUE_DEPTH)
         send_op(($urandom_range(0, 99) < 97) ? mtq_pkg::OP_ENQ : mtq_pkg::OP_DEQ,
                 pick_value());
      repeat (3) send_op(mtq_pkg::OP_ENQ, pick_value());
      random_ops(100, 50);

      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      random_ops(200, 30);

      req_chan.valid <= 1'b0;
      while (checker_q.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (checker_q.error_count == 0 && checker_q.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
